// File: rtl/core/kmsd_pkg.sv
// Shared types and constants for the key matrix scanner with global debounce.
`default_nettype none

package kmsd_pkg;

  localparam int KIND_W       = 2;
  localparam int COLUMN_W     = 4;
  localparam int ROW_BITS_W   = 8;
  localparam int ROW_INDEX_W  = 3;
  localparam int STABLE_ROW_W = 16;
  localparam int TICK_W       = 8;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 8;

  localparam logic [TICK_W-1:0]      TICK_MAX       = 8'hFF;
  localparam logic [TICK_W-1:0]      DEBOUNCE_RESET = 8'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LOW  = 1'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [COLUMN_W-1:0]    column;
    logic [ROW_BITS_W-1:0]  row_bits;
    logic                   last_column;
    logic [ROW_INDEX_W-1:0] row_index;
  } item_t;

  typedef struct packed {
    logic [STABLE_ROW_W-1:0] stable_row;
    logic                    key_on;
    logic                    any_key_down;
    logic                    debounce_active;
    logic                    stable_updated;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/kmsd_in_reg.sv
// Input register stage: holds one accepted item until the engine takes it.
`default_nettype none

module kmsd_in_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            advance,
  input  wire kmsd_pkg::item_t item_in,
  output logic                 in_stall,
  output logic                 item_valid,
  output kmsd_pkg::item_t      item
);

  logic load;

  // The stage holds its item while the result side cannot move.
  assign in_stall = item_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/kmsd_engine.sv
// Matrix state, debounce timer and the per-item update and read logic.
`default_nettype none

module kmsd_engine #(
  parameter int ROWS = 8,
  parameter int COLS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [kmsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [kmsd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 fire,
  input  wire kmsd_pkg::item_t                      item,
  output kmsd_pkg::result_t                         result
);

  localparam int RBW = (ROWS > kmsd_pkg::ROW_BITS_W) ? ROWS : kmsd_pkg::ROW_BITS_W;
  localparam int CBW = (COLS > kmsd_pkg::STABLE_ROW_W) ? COLS : kmsd_pkg::STABLE_ROW_W;

  logic [COLS-1:0]               raw_matrix [ROWS];
  logic [COLS-1:0]               stable_matrix [ROWS];
  logic                          scan_changed;
  logic                          debounce_busy;
  logic [kmsd_pkg::TICK_W-1:0]   elapsed_ticks;
  logic                          any_down;
  logic [kmsd_pkg::TICK_W-1:0]   debounce_ms;
  logic                          active_low;

  logic [COLS-1:0]               raw_matrix_next [ROWS];
  logic [COLS-1:0]               stable_matrix_next [ROWS];
  logic                          scan_changed_next;
  logic                          debounce_busy_next;
  logic [kmsd_pkg::TICK_W-1:0]   elapsed_ticks_next;
  logic                          any_down_next;

  always_comb begin
    logic [kmsd_pkg::ROW_BITS_W-1:0] bits8;
    logic [RBW-1:0]                  bits_w;
    logic [COLS-1:0]                 cmask;
    logic [COLS-1:0]                 nv;
    logic [COLS-1:0]                 sel;
    logic [COLS-1:0]                 raw_or;
    logic [CBW-1:0]                  sel_w;
    logic                            changed;

    raw_matrix_next    = raw_matrix;
    stable_matrix_next = stable_matrix;
    scan_changed_next  = scan_changed;
    debounce_busy_next = debounce_busy;
    elapsed_ticks_next = elapsed_ticks;
    any_down_next      = any_down;
    result             = '0;

    bits8   = active_low ? ~item.row_bits : item.row_bits;
    bits_w  = RBW'(bits8);
    changed = 1'b0;
    sel     = '0;
    raw_or  = '0;
    nv      = '0;

    // A column outside the matrix gives an empty mask, so nothing is written.
    for (int c = 0; c < COLS; c++) begin
      cmask[c] = (32'(item.column) == c);
    end

    case (kmsd_pkg::kind_t'(item.kind))
      kmsd_pkg::KIND_SAMPLE: begin
        for (int r = 0; r < ROWS; r++) begin
          nv = bits_w[r] ? (raw_matrix[r] | cmask) : (raw_matrix[r] & ~cmask);
          if (nv != raw_matrix[r]) begin
            changed = 1'b1;
          end
          raw_matrix_next[r] = nv;
          raw_or = raw_or | nv;
        end
        scan_changed_next = scan_changed | changed;
        if (item.last_column) begin
          // A change seen during a running interval does not restart it.
          if (scan_changed_next && !debounce_busy) begin
            debounce_busy_next = 1'b1;
            elapsed_ticks_next = '0;
          end
          scan_changed_next = 1'b0;
          if (debounce_busy_next && (elapsed_ticks_next > debounce_ms)) begin
            stable_matrix_next       = raw_matrix_next;
            debounce_busy_next       = 1'b0;
            any_down_next            = |raw_or;
            result.stable_updated    = 1'b1;
          end
        end
      end
      kmsd_pkg::KIND_TICK: begin
        if (elapsed_ticks != kmsd_pkg::TICK_MAX) begin
          elapsed_ticks_next = elapsed_ticks + 1'b1;
        end
      end
      kmsd_pkg::KIND_READ: begin
        for (int r = 0; r < ROWS; r++) begin
          if (32'(item.row_index) == r) begin
            sel = stable_matrix[r];
          end
        end
        sel_w             = CBW'(sel);
        result.stable_row = sel_w[kmsd_pkg::STABLE_ROW_W-1:0];
        result.key_on     = |(sel & cmask);
      end
      default: begin
      end
    endcase

    result.any_key_down    = any_down_next;
    result.debounce_active = debounce_busy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        raw_matrix[r]    <= '0;
        stable_matrix[r] <= '0;
      end
      scan_changed  <= 1'b0;
      debounce_busy <= 1'b0;
      elapsed_ticks <= '0;
      any_down      <= 1'b0;
    end else if (fire) begin
      raw_matrix    <= raw_matrix_next;
      stable_matrix <= stable_matrix_next;
      scan_changed  <= scan_changed_next;
      debounce_busy <= debounce_busy_next;
      elapsed_ticks <= elapsed_ticks_next;
      any_down      <= any_down_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= kmsd_pkg::DEBOUNCE_RESET;
      active_low  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        kmsd_pkg::REG_DEBOUNCE_MS: debounce_ms <= cfg_data;
        kmsd_pkg::REG_ACTIVE_LOW:  active_low  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/key_matrix_scan_debounce_core.sv
// Top level of the key matrix scanner with one global debounce timer.
//
//   channel  direction  handshake           contents
//   input    in         in_valid/in_stall   kind, column, row_bits, last_column, row_index
//   output   out        out_valid/out_stall stable_row, key_on, any_key_down,
//                                           debounce_active, stable_updated
//   config   in         cfg_write           cfg_index, cfg_data (no read-back)
//
// An accepted item sits in the input register while the update logic works on
// it, and its result is then captured in the result register, which offers it
// on the output; one item per cycle goes through while the output is not
// stalled, with a single pass from input register to result register.
// Reset clears both matrices, the debounce state and the config registers to defaults.
// A stalled result holds the input register; a new item is still taken when
// the result register is being emptied in the same cycle.
`default_nettype none

module key_matrix_scan_debounce_core #(
  parameter int ROWS = 8,
  parameter int COLS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [kmsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [kmsd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [kmsd_pkg::KIND_W-1:0]          kind,
  input  wire logic [kmsd_pkg::COLUMN_W-1:0]        column,
  input  wire logic [kmsd_pkg::ROW_BITS_W-1:0]      row_bits,
  input  wire logic                                 last_column,
  input  wire logic [kmsd_pkg::ROW_INDEX_W-1:0]     row_index,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [kmsd_pkg::STABLE_ROW_W-1:0]         stable_row,
  output logic                                      key_on,
  output logic                                      any_key_down,
  output logic                                      debounce_active,
  output logic                                      stable_updated
);

  kmsd_pkg::item_t   item_in;
  kmsd_pkg::item_t   item;
  kmsd_pkg::result_t result_next;
  kmsd_pkg::result_t result;
  logic              item_valid;
  logic              advance;
  logic              fire;

  assign item_in.kind        = kind;
  assign item_in.column      = column;
  assign item_in.row_bits    = row_bits;
  assign item_in.last_column = last_column;
  assign item_in.row_index   = row_index;

  // The result register can take a new result when empty or being drained.
  assign advance = !out_valid || !out_stall;
  assign fire    = item_valid && advance;

  kmsd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .advance    (advance),
    .item_in    (item_in),
    .in_stall   (in_stall),
    .item_valid (item_valid),
    .item       (item)
  );

  kmsd_engine #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item),
    .result    (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  assign stable_row      = result.stable_row;
  assign key_on          = result.key_on;
  assign any_key_down    = result.any_key_down;
  assign debounce_active = result.debounce_active;
  assign stable_updated  = result.stable_updated;

endmodule

`default_nettype wire

// File: rtl/core/kmsd_checker.sv
// Port-level checks for the key matrix scanner, bound to the top level.
`default_nettype none

module kmsd_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 out_valid,
  input wire logic                                 out_stall,
  input wire logic [kmsd_pkg::STABLE_ROW_W-1:0]    stable_row,
  input wire logic                                 key_on,
  input wire logic                                 any_key_down,
  input wire logic                                 debounce_active,
  input wire logic                                 stable_updated
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(stable_row) && $stable(key_on)
      && $stable(stable_updated) && $stable(debounce_active))
    else $error("stalled result transfer changed");

  // Copying raw into stable always ends the running debounce interval.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && stable_updated |-> !debounce_active)
    else $error("debounce still active after stable update");

  // A pressed stable key means the matrix is not empty.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && key_on |-> any_key_down && (stable_row != '0))
    else $error("key_on without stable bits");

  // Any stable bit shown in a row must be reflected by the any-key flag.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (stable_row != '0) |-> any_key_down)
    else $error("stable row bits without any_key_down");

endmodule

bind key_matrix_scan_debounce_core kmsd_checker u_kmsd_checker (.*);

`default_nettype wire
